// ===== rtl/png_chunk_stream_parser_assert.svh =====
// Assertion macros for the PNG chunk stream parser.
// Depends on clk and arst_n being in scope where a macro is used.
`ifndef PNG_CHUNK_STREAM_PARSER_ASSERT_SVH
`define PNG_CHUNK_STREAM_PARSER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define PCSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PCSP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/pcsp_pkg.sv =====
// Shared types, codes and tables for the PNG chunk stream parser.
// No dependencies; used by every module of the block.
`default_nettype none

package pcsp_pkg;

	localparam int CHUNK_COUNT_MAX_DEF = 65535;
	localparam int QUEUE_DEPTH_DEF     = 4;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_CHUNK = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// error codes
	localparam logic [3:0] ERR_SIGNATURE   = 4'd0;
	localparam logic [3:0] ERR_FIRST_TYPE  = 4'd1;
	localparam logic [3:0] ERR_IHDR_LENGTH = 4'd2;
	localparam logic [3:0] ERR_COLOR       = 4'd3;
	localparam logic [3:0] ERR_DEPTH       = 4'd4;
	localparam logic [3:0] ERR_COMPRESSION = 4'd5;
	localparam logic [3:0] ERR_FILTER      = 4'd6;
	localparam logic [3:0] ERR_INTERLACE   = 4'd7;
	localparam logic [3:0] ERR_LAST_TYPE   = 4'd8;
	localparam logic [3:0] ERR_TRUNCATED   = 4'd9;

	localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

	// one result record as it travels from the front to the back
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [31:0] chunk_type;
		logic [30:0] chunk_length;
		logic [31:0] chunk_crc;
		logic [15:0] chunk_index;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic [7:0]  bit_depth;
		logic [7:0]  color_type;
		logic        interlaced;
		logic [3:0]  error_code;
	} rec_t;

	// file signature bytes in order
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] v;
		unique case (idx)
			3'd0: v = 8'd137;
			3'd1: v = 8'd80;
			3'd2: v = 8'd78;
			3'd3: v = 8'd71;
			3'd4: v = 8'd13;
			3'd5: v = 8'd10;
			3'd6: v = 8'd26;
			3'd7: v = 8'd10;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pcsp_front.sv =====
// Front end of the PNG chunk stream parser: byte framing, header checks, record build.
// Depends on pcsp_pkg.
`default_nettype none

module pcsp_front #(
	parameter int CHUNK_COUNT_MAX = pcsp_pkg::CHUNK_COUNT_MAX_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                accept,
	input  wire [7:0]          in_byte,
	input  wire                last_of_file,
	output logic               rec_valid,
	output pcsp_pkg::rec_t     rec
);

	localparam logic [2:0] PH_SIG  = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_TYPE = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CRC  = 3'd4;

	localparam logic [15:0] CNT_MAX = 16'(CHUNK_COUNT_MAX);

	logic [2:0]  phase_q, phase_n;
	logic [30:0] fc_q, fc_n;
	logic [31:0] len_q, len_n;
	logic [31:0] type_q, type_n;
	logic [31:0] crc_q, crc_n;
	logic [15:0] cnt_q, cnt_n;
	logic        fault_q, fault_n;
	logic [7:0]  hdr_q [13];

	logic [31:0] fc_inc;
	logic [31:0] len_sh, type_sh, crc_sh;
	logic [15:0] cnt_sat;
	logic        hdr_we;
	logic        hf_v;
	logic [3:0]  hf_code;
	logic        err_v;
	logic [3:0]  err_code;
	logic        emit;
	logic        rearm;
	logic        acc;
	logic [15:0] cnt_put;
	logic        depth_ok;

	assign fc_inc  = {1'b0, fc_q} + 32'd1;
	assign len_sh  = {len_q[23:0], in_byte};
	assign type_sh = {type_q[23:0], in_byte};
	assign crc_sh  = {crc_q[23:0], in_byte};
	assign cnt_sat = (cnt_q < CNT_MAX) ? (cnt_q + 16'd1) : cnt_q;

	// header field checks, in reporting order
	always_comb begin
		depth_ok = 1'b0;
		hf_v     = 1'b0;
		hf_code  = pcsp_pkg::ERR_COLOR;
		unique case (hdr_q[9])
			8'd0: depth_ok = (hdr_q[8] == 8'd1) || (hdr_q[8] == 8'd2) ||
				(hdr_q[8] == 8'd4) || (hdr_q[8] == 8'd8) || (hdr_q[8] == 8'd16);
			8'd2, 8'd4, 8'd6: depth_ok = (hdr_q[8] == 8'd8) || (hdr_q[8] == 8'd16);
			8'd3: depth_ok = (hdr_q[8] == 8'd1) || (hdr_q[8] == 8'd2) ||
				(hdr_q[8] == 8'd4) || (hdr_q[8] == 8'd8);
			default: begin
				hf_v    = 1'b1;
				hf_code = pcsp_pkg::ERR_COLOR;
			end
		endcase
		priority if (hf_v) begin
			hf_code = pcsp_pkg::ERR_COLOR;
		end else if (!depth_ok) begin
			hf_v    = 1'b1;
			hf_code = pcsp_pkg::ERR_DEPTH;
		end else if (hdr_q[10] != 8'd0) begin
			hf_v    = 1'b1;
			hf_code = pcsp_pkg::ERR_COMPRESSION;
		end else if (hdr_q[11] > 8'd4) begin
			hf_v    = 1'b1;
			hf_code = pcsp_pkg::ERR_FILTER;
		end else if (hdr_q[12] > 8'd1) begin
			hf_v    = 1'b1;
			hf_code = pcsp_pkg::ERR_INTERLACE;
		end else begin
			hf_v = 1'b0;
		end
	end

	// per-byte parse step
	always_comb begin
		phase_n  = phase_q;
		fc_n     = fc_q;
		len_n    = len_q;
		type_n   = type_q;
		crc_n    = crc_q;
		cnt_n    = cnt_q;
		fault_n  = fault_q;
		hdr_we   = 1'b0;
		err_v    = 1'b0;
		err_code = pcsp_pkg::ERR_SIGNATURE;
		emit     = 1'b0;
		rearm    = 1'b0;
		cnt_put  = cnt_q;
		rec              = '0;
		rec.chunk_index  = cnt_q;

		if (fault_q) begin
			rearm = last_of_file;
		end else begin
			unique case (phase_q)
				PH_SIG: begin
					if (in_byte != pcsp_pkg::sig_byte(fc_q[2:0])) begin
						err_v    = 1'b1;
						err_code = pcsp_pkg::ERR_SIGNATURE;
					end else if (fc_q[2:0] == 3'd7) begin
						fc_n    = '0;
						phase_n = PH_LEN;
					end else begin
						fc_n = fc_inc[30:0];
					end
				end
				PH_LEN: begin
					len_n = len_sh;
					if (fc_q[1:0] == 2'd3) begin
						fc_n = '0;
						if (len_sh[31]) begin
							err_v    = 1'b1;
							err_code = pcsp_pkg::ERR_TRUNCATED;
						end else begin
							phase_n = PH_TYPE;
						end
					end else begin
						fc_n = fc_inc[30:0];
					end
				end
				PH_TYPE: begin
					type_n = type_sh;
					if (fc_q[1:0] == 2'd3) begin
						fc_n = '0;
						priority if (cnt_q == 16'd0 && type_sh != pcsp_pkg::TYPE_IHDR) begin
							err_v    = 1'b1;
							err_code = pcsp_pkg::ERR_FIRST_TYPE;
						end else if (cnt_q == 16'd0 && len_q != 32'd13) begin
							err_v    = 1'b1;
							err_code = pcsp_pkg::ERR_IHDR_LENGTH;
						end else begin
							phase_n = (len_q != 32'd0) ? PH_DATA : PH_CRC;
						end
					end else begin
						fc_n = fc_inc[30:0];
					end
				end
				PH_DATA: begin
					hdr_we = (cnt_q == 16'd0) && (fc_q < 31'd13);
					if (fc_inc >= len_q) begin
						fc_n    = '0;
						phase_n = PH_CRC;
					end else begin
						fc_n = fc_inc[30:0];
					end
					if (!last_of_file) begin
						emit              = 1'b1;
						rec.kind          = pcsp_pkg::KIND_DATA;
						rec.data_byte     = in_byte;
						rec.chunk_type    = type_q;
						rec.chunk_length  = len_q[30:0];
					end
				end
				default: begin
					// CRC bytes; the record goes out on the last one
					crc_n = crc_sh;
					if (fc_q[1:0] == 2'd3) begin
						priority if (cnt_q == 16'd0 && hf_v) begin
							err_v    = 1'b1;
							err_code = hf_code;
						end else if (last_of_file && type_q != pcsp_pkg::TYPE_IEND) begin
							err_v    = 1'b1;
							err_code = pcsp_pkg::ERR_LAST_TYPE;
						end else begin
							emit             = 1'b1;
							cnt_n            = cnt_sat;
							cnt_put          = cnt_sat;
							rec.kind         = last_of_file ? pcsp_pkg::KIND_DONE :
								pcsp_pkg::KIND_CHUNK;
							rec.chunk_type   = type_q;
							rec.chunk_length = len_q[30:0];
							rec.chunk_crc    = crc_sh;
							rearm            = last_of_file;
							phase_n          = PH_LEN;
							fc_n             = '0;
							len_n            = '0;
							type_n           = '0;
							crc_n            = '0;
						end
					end else begin
						fc_n = fc_inc[30:0];
					end
				end
			endcase

			// end of file anywhere else is a truncation
			if (!err_v && !emit && last_of_file) begin
				err_v    = 1'b1;
				err_code = pcsp_pkg::ERR_TRUNCATED;
			end
			if (err_v) begin
				emit           = 1'b1;
				rec            = '0;
				rec.kind       = pcsp_pkg::KIND_ERROR;
				rec.chunk_index = cnt_q;
				rec.error_code = err_code;
				rearm          = last_of_file;
				fault_n        = !last_of_file;
			end
		end

		// header fields once IHDR has been accepted
		acc = (cnt_put != 16'd0);
		if (acc) begin
			rec.image_width  = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]};
			rec.image_height = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
			rec.bit_depth    = hdr_q[8];
			rec.color_type   = hdr_q[9];
			rec.interlaced   = hdr_q[12][0];
		end

		if (rearm) begin
			phase_n = PH_SIG;
			fc_n    = '0;
			len_n   = '0;
			type_n  = '0;
			crc_n   = '0;
			cnt_n   = '0;
			fault_n = 1'b0;
		end
	end

	assign rec_valid = accept && emit;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			fc_q    <= '0;
			len_q   <= '0;
			type_q  <= '0;
			crc_q   <= '0;
			cnt_q   <= '0;
			fault_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			fc_q    <= fc_n;
			len_q   <= len_n;
			type_q  <= type_n;
			crc_q   <= crc_n;
			cnt_q   <= cnt_n;
			fault_q <= fault_n;
		end
	end

	// IHDR data bytes, no reset
	always_ff @(posedge clk) begin
		if (accept && hdr_we) begin
			hdr_q[fc_q[3:0]] <= in_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pcsp_queue.sv =====
// Short record queue between the parser front and the output stage.
// Depends on pcsp_pkg and png_chunk_stream_parser_assert.svh.
`default_nettype none

`include "png_chunk_stream_parser_assert.svh"

module pcsp_queue #(
	parameter int DEPTH = pcsp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  pcsp_pkg::rec_t     push_rec,
	input  wire                pop,
	output pcsp_pkg::rec_t     head_rec,
	output logic               empty,
	output logic               full
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	pcsp_pkg::rec_t    mem_q [DEPTH];
	logic [ADDR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0]  count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign head_rec = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == ADDR_W'(DEPTH - 1)) ? '0 : wr_q + ADDR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == ADDR_W'(DEPTH - 1)) ? '0 : rd_q + ADDR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`PCSP_ASSERT_NEVER(a_no_push_full, push && full && !pop, "queue push while full")
	`PCSP_ASSERT_NEVER(a_no_pop_empty, pop && empty, "queue pop while empty")
	`PCSP_ASSERT(a_drain, (pop && !push && count_q == CNT_W'(1)) |=> empty, "queue not drained")

endmodule

`default_nettype wire

// ===== rtl/pcsp_back.sv =====
// Output stage of the PNG chunk stream parser: result register and stream packing.
// Depends on pcsp_pkg and png_chunk_stream_parser_assert.svh.
`default_nettype none

`include "png_chunk_stream_parser_assert.svh"

module pcsp_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                q_empty,
	input  pcsp_pkg::rec_t     q_head,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  wire                m_axis_tready,
	output logic [207:0]       m_axis_tdata,
	output logic [1:0]         m_axis_tuser
);

	pcsp_pkg::rec_t out_q;
	logic           valid_q;

	// refill the output register when it is free or being taken
	assign pop = !q_empty && (!valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_head;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {4'b0000, out_q.error_code, out_q.interlaced, out_q.color_type,
		out_q.bit_depth, out_q.image_height, out_q.image_width, out_q.chunk_index,
		out_q.chunk_crc, out_q.chunk_length, out_q.chunk_type, out_q.data_byte};

	`PCSP_ASSERT(a_load_shows, pop |=> m_axis_tvalid, "loaded result not presented")

endmodule

`default_nettype wire

// ===== rtl/png_chunk_stream_parser.sv =====
// Top level of the PNG chunk stream parser: front, record queue and output stage.
// Depends on pcsp_pkg, pcsp_front, pcsp_queue and pcsp_back.
//
//  port group | dir | width        | carries
//  s_axis     | in  | 8 + tlast    | file bytes, tlast on the final byte of the file
//  m_axis     | out | 208 + tuser2 | data bytes, chunk records, done and error results
//
// One byte is taken per cycle while the record queue is not full; the parse state is registered as each byte is taken.
// A result passes through the record queue, then the output register, before it appears on m_axis.
// s_axis_tready drops only when the record queue is full; it holds QUEUE_DEPTH results
// besides the one in the output register, so the input stalls only on a stalled output.
// arst_n clears the parser state, queue pointers and output valid; no clearing pass.
`default_nettype none

module png_chunk_stream_parser #(
	parameter int CHUNK_COUNT_MAX = pcsp_pkg::CHUNK_COUNT_MAX_DEF,
	parameter int QUEUE_DEPTH     = pcsp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// [7:0] in_byte
	input  wire  [7:0]   s_axis_tdata,
	// last_of_file
	input  wire          s_axis_tlast,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// [7:0] data_byte, [39:8] chunk_type, [70:40] chunk_length, [102:71] chunk_crc,
	// [118:103] chunk_index, [150:119] image_width, [182:151] image_height,
	// [190:183] bit_depth, [198:191] color_type, [199] interlaced,
	// [203:200] error_code, [207:204] zero
	output logic [207:0] m_axis_tdata,
	// [1:0] kind
	output logic [1:0]   m_axis_tuser
);

	logic           accept;
	logic           rec_valid;
	pcsp_pkg::rec_t rec;
	pcsp_pkg::rec_t head_rec;
	logic           q_empty;
	logic           q_full;
	logic           pop;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && !q_full;

	pcsp_front #(
		.CHUNK_COUNT_MAX(CHUNK_COUNT_MAX)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (s_axis_tdata),
		.last_of_file (s_axis_tlast),
		.rec_valid    (rec_valid),
		.rec          (rec)
	);

	pcsp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rec_valid),
		.push_rec (rec),
		.pop      (pop),
		.head_rec (head_rec),
		.empty    (q_empty),
		.full     (q_full)
	);

	pcsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (head_rec),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ===== bench/png_parse_checker.sv =====
`timescale 1ns / 100ps
// Checker for the PNG chunk stream parser: watches both stream channels,
// predicts each result from the accepted file bytes and compares field by field.
// Depends on pcsp_pkg for result kinds, error codes, chunk types and the record layout.

module png_parse_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [207:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           mismatch_count,
	output int           records_pending
);

	localparam logic [63:0] PNG_MAGIC         = 64'h8950_4E47_0D0A_1A0A;
	localparam int          CHUNK_LIMIT       = pcsp_pkg::CHUNK_COUNT_MAX_DEF;
	localparam logic [7:0]  COLOR_GRAY        = 8'd0;
	localparam logic [7:0]  COLOR_RGB         = 8'd2;
	localparam logic [7:0]  COLOR_PALETTE     = 8'd3;
	localparam logic [7:0]  COLOR_GRAY_ALPHA  = 8'd4;
	localparam logic [7:0]  COLOR_RGBA        = 8'd6;
	localparam logic [7:0]  MAX_FILTER_METHOD = 8'd4;
	localparam logic [7:0]  MAX_INTERLACE     = 8'd1;

	// parse phases
	localparam logic [2:0] AT_SIGNATURE = 3'd0;
	localparam logic [2:0] AT_LENGTH    = 3'd1;
	localparam logic [2:0] AT_TYPE      = 3'd2;
	localparam logic [2:0] AT_DATA      = 3'd3;
	localparam logic [2:0] AT_CRC       = 3'd4;

	// predicted parser state
	logic [2:0]   phase;
	logic [31:0]  field_cnt;
	logic [31:0]  len_word;
	logic [31:0]  type_word;
	logic [31:0]  crc_word;
	logic [15:0]  chunk_cnt;
	logic [7:0]   hdr [13];
	logic         fault_seen;

	pcsp_pkg::rec_t expected_records [$];

	// back to the start of a file
	task automatic rearm();
		phase      = AT_SIGNATURE;
		field_cnt  = '0;
		len_word   = '0;
		type_word  = '0;
		crc_word   = '0;
		chunk_cnt  = '0;
		fault_seen = 1'b0;
	endtask

	// header fields are reported only once the IHDR chunk has been accepted
	task automatic push_record(input logic [1:0] kind, input logic [7:0] data,
			input logic [31:0] ctype, input logic [30:0] len, input logic [31:0] crc,
			input logic [15:0] idx, input logic [3:0] code);
		pcsp_pkg::rec_t rec;
		logic seen_hdr;
		seen_hdr         = chunk_cnt != 0;
		rec.kind         = kind;
		rec.data_byte    = data;
		rec.chunk_type   = ctype;
		rec.chunk_length = len;
		rec.chunk_crc    = crc;
		rec.chunk_index  = idx;
		rec.image_width  = seen_hdr ? {hdr[0], hdr[1], hdr[2], hdr[3]} : 32'd0;
		rec.image_height = seen_hdr ? {hdr[4], hdr[5], hdr[6], hdr[7]} : 32'd0;
		rec.bit_depth    = seen_hdr ? hdr[8] : 8'd0;
		rec.color_type   = seen_hdr ? hdr[9] : 8'd0;
		rec.interlaced   = seen_hdr ? hdr[12][0] : 1'b0;
		rec.error_code   = code;
		expected_records.push_back(rec);
	endtask

	// colour/depth pairing, then compression, filter and interlace, in that order
	function automatic logic header_fault(output logic [3:0] code);
		logic [7:0] depth;
		logic [7:0] ctype;
		logic       color_ok;
		logic       depth_ok;
		depth    = hdr[8];
		ctype    = hdr[9];
		color_ok = 1'b1;
		case (ctype)
			COLOR_GRAY: depth_ok = depth == 1 || depth == 2 || depth == 4 || depth == 8 ||
				depth == 16;
			COLOR_RGB, COLOR_GRAY_ALPHA, COLOR_RGBA: depth_ok = depth == 8 || depth == 16;
			COLOR_PALETTE: depth_ok = depth == 1 || depth == 2 || depth == 4 || depth == 8;
			default: begin
				color_ok = 1'b0;
				depth_ok = 1'b0;
			end
		endcase
		header_fault = 1'b1;
		code         = pcsp_pkg::ERR_COLOR;
		if (!color_ok)
			code = pcsp_pkg::ERR_COLOR;
		else if (!depth_ok)
			code = pcsp_pkg::ERR_DEPTH;
		else if (hdr[10] != 8'd0)
			code = pcsp_pkg::ERR_COMPRESSION;
		else if (hdr[11] > MAX_FILTER_METHOD)
			code = pcsp_pkg::ERR_FILTER;
		else if (hdr[12] > MAX_INTERLACE)
			code = pcsp_pkg::ERR_INTERLACE;
		else
			header_fault = 1'b0;
	endfunction

	// one accepted file byte: update the state and queue what it should produce
	task automatic parse_png_byte(input logic [7:0] b, input logic last);
		logic        fault;
		logic [3:0]  code;
		logic        emitted;
		logic [15:0] idx;
		int          sig_pos;
		fault   = 1'b0;
		code    = pcsp_pkg::ERR_SIGNATURE;
		emitted = 1'b0;
		if (fault_seen) begin
			if (last)
				rearm();
		end else begin
			case (phase)
				AT_SIGNATURE: begin
					sig_pos = 63 - 8 * field_cnt[2:0];
					if (b != PNG_MAGIC[sig_pos -: 8]) begin
						fault = 1'b1;
						code  = pcsp_pkg::ERR_SIGNATURE;
					end else begin
						field_cnt++;
						if (field_cnt >= 8) begin
							field_cnt = '0;
							phase     = AT_LENGTH;
						end
					end
				end
				AT_LENGTH: begin
					len_word = {len_word[23:0], b};
					field_cnt++;
					if (field_cnt >= 4) begin
						field_cnt = '0;
						// lengths beyond 31 bits are treated as a broken file
						if (len_word[31]) begin
							fault = 1'b1;
							code  = pcsp_pkg::ERR_TRUNCATED;
						end else begin
							phase = AT_TYPE;
						end
					end
				end
				AT_TYPE: begin
					type_word = {type_word[23:0], b};
					field_cnt++;
					if (field_cnt >= 4) begin
						field_cnt = '0;
						if (chunk_cnt == 0 && type_word != pcsp_pkg::TYPE_IHDR) begin
							fault = 1'b1;
							code  = pcsp_pkg::ERR_FIRST_TYPE;
						end else if (chunk_cnt == 0 && len_word != 32'd13) begin
							fault = 1'b1;
							code  = pcsp_pkg::ERR_IHDR_LENGTH;
						end else begin
							phase = (len_word != 0) ? AT_DATA : AT_CRC;
						end
					end
				end
				AT_DATA: begin
					if (chunk_cnt == 0 && field_cnt < 13)
						hdr[field_cnt] = b;
					field_cnt++;
					if (field_cnt >= len_word) begin
						field_cnt = '0;
						phase     = AT_CRC;
					end
					// a data byte on the final transfer is dropped and reported as truncation
					if (!last) begin
						push_record(pcsp_pkg::KIND_DATA, b, type_word, len_word[30:0], '0,
							chunk_cnt, pcsp_pkg::ERR_SIGNATURE);
						emitted = 1'b1;
					end
				end
				default: begin
					crc_word = {crc_word[23:0], b};
					field_cnt++;
					if (field_cnt >= 4) begin
						idx = chunk_cnt;
						if (chunk_cnt == 0)
							fault = header_fault(code);
						if (!fault && last && type_word != pcsp_pkg::TYPE_IEND) begin
							fault = 1'b1;
							code  = pcsp_pkg::ERR_LAST_TYPE;
						end
						if (!fault) begin
							if (chunk_cnt < CHUNK_LIMIT)
								chunk_cnt++;
							emitted = 1'b1;
							if (last) begin
								push_record(pcsp_pkg::KIND_DONE, '0, type_word, len_word[30:0],
									crc_word, idx, pcsp_pkg::ERR_SIGNATURE);
								rearm();
							end else begin
								push_record(pcsp_pkg::KIND_CHUNK, '0, type_word, len_word[30:0],
									crc_word, idx, pcsp_pkg::ERR_SIGNATURE);
								phase     = AT_LENGTH;
								field_cnt = '0;
								len_word  = '0;
								type_word = '0;
								crc_word  = '0;
							end
						end
					end
				end
			endcase
			// a fault of the byte itself wins over truncation
			if (!emitted) begin
				if (!fault && last) begin
					fault = 1'b1;
					code  = pcsp_pkg::ERR_TRUNCATED;
				end
				if (fault) begin
					push_record(pcsp_pkg::KIND_ERROR, '0, '0, '0, '0, chunk_cnt, code);
					if (last)
						rearm();
					else
						fault_seen = 1'b1;
				end
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// one output transfer against the oldest prediction
	task automatic check_result(input logic [207:0] d, input logic [1:0] k);
		pcsp_pkg::rec_t want;
		if (expected_records.size() == 0) begin
			$display("%0t: result with none expected, expected none, actual kind %0h tdata %h",
				$time, k, d);
			mismatch_count++;
		end else begin
			want = expected_records.pop_front();
			compare_field("kind", want.kind, k);
			compare_field("data_byte", want.data_byte, d[7:0]);
			compare_field("chunk_type", want.chunk_type, d[39:8]);
			compare_field("chunk_length", want.chunk_length, d[70:40]);
			compare_field("chunk_crc", want.chunk_crc, d[102:71]);
			compare_field("chunk_index", want.chunk_index, d[118:103]);
			compare_field("image_width", want.image_width, d[150:119]);
			compare_field("image_height", want.image_height, d[182:151]);
			compare_field("bit_depth", want.bit_depth, d[190:183]);
			compare_field("color_type", want.color_type, d[198:191]);
			compare_field("interlaced", want.interlaced, d[199]);
			compare_field("error_code", want.error_code, d[203:200]);
			compare_field("pad", 32'd0, d[207:204]);
		end
	endtask

	// results leave only through the record queue and output register, so order within an edge is free
	always @(posedge clk) begin
		if (!arst_n) begin
			rearm();
			for (int i = 0; i < 13; i++)
				hdr[i] = 8'd0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata, m_tuser);
			if (s_tvalid && s_tready)
				parse_png_byte(s_tdata, s_tlast);
		end
		records_pending = expected_records.size();
	end

endmodule

// ===== bench/tb_png_chunk_stream_parser.sv =====
`timescale 1ns / 100ps
// Testbench top for the PNG chunk stream parser: clock, reset, file stimulus
// and output back-pressure; checking is done by png_parse_checker.
// Depends on pcsp_pkg, png_chunk_stream_parser and png_parse_checker.

module tb_png_chunk_stream_parser;

	localparam logic [63:0] FILE_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
	localparam int          STALL_CYCLES   = 300;
	localparam int          PHASE_BYTES    = 300;
	localparam int          RUN_LIMIT_NS   = 5_000_000;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata  = 8'd0;
	logic         s_axis_tlast  = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [207:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	int mismatch_count;
	int records_pending;
	int src_idle_pct  = 0;
	int rcv_idle_pct  = 0;
	int stalls_asked  = 0;
	int stalls_done   = 0;
	int stall_left    = 0;

	logic [7:0] file_q [$];

	png_chunk_stream_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	png_parse_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_axis_tvalid),
		.s_tready        (s_axis_tready),
		.s_tdata         (s_axis_tdata),
		.s_tlast         (s_axis_tlast),
		.m_tvalid        (m_axis_tvalid),
		.m_tready        (m_axis_tready),
		.m_tdata         (m_axis_tdata),
		.m_tuser         (m_axis_tuser),
		.mismatch_count  (mismatch_count),
		.records_pending (records_pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

	// receiver: random back-pressure, plus a long hold-off when one is asked for
	initial begin
		forever begin
			@(negedge clk);
			if (stalls_done != stalls_asked) begin
				stalls_done++;
				stall_left = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= $urandom_range(99) >= rcv_idle_pct;
			end
		end
	end

	// one byte transfer; entered and left just after a falling edge
	task automatic send_byte(input logic [7:0] value, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom);
			s_axis_tlast  <= 1'($urandom_range(1));
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	task automatic push_word(input logic [31:0] w);
		file_q.push_back(w[31:24]);
		file_q.push_back(w[23:16]);
		file_q.push_back(w[15:8]);
		file_q.push_back(w[7:0]);
	endtask

	function automatic logic [7:0] type_letter();
		return 8'(8'h41 + $urandom_range(25) + ($urandom_range(1) ? 8'h20 : 8'h00));
	endfunction

	// a well-formed file with random content, then at most one kind of damage
	task automatic build_png_file(input bit big_chunk);
		logic [7:0]  ctype;
		logic [7:0]  depth;
		logic [31:0] chunk_len;
		int          len_pos [$];
		int          extra;
		int          iend_type_pos;
		int          pos;
		file_q.delete();
		for (int i = 0; i < 8; i++)
			file_q.push_back(FILE_SIGNATURE[63 - 8 * i -: 8]);

		// legal colour type and depth pairs
		case ($urandom_range(4))
			0: begin
				ctype = 8'd0;
				depth = 8'd1 << $urandom_range(4);
			end
			1: begin
				ctype = 8'd2;
				depth = $urandom_range(1) ? 8'd8 : 8'd16;
			end
			2: begin
				ctype = 8'd3;
				depth = 8'd1 << $urandom_range(3);
			end
			3: begin
				ctype = 8'd4;
				depth = $urandom_range(1) ? 8'd8 : 8'd16;
			end
			default: begin
				ctype = 8'd6;
				depth = $urandom_range(1) ? 8'd8 : 8'd16;
			end
		endcase

		// header chunk: width, height, depth, colour, compression, filter, interlace
		len_pos.push_back(file_q.size());
		push_word(32'd13);
		push_word(pcsp_pkg::TYPE_IHDR);
		push_word($urandom);
		push_word($urandom);
		file_q.push_back(depth);
		file_q.push_back(ctype);
		file_q.push_back(8'd0);
		file_q.push_back(8'($urandom_range(4)));
		file_q.push_back(8'($urandom_range(1)));
		push_word($urandom);

		// ancillary chunks, sometimes an IEND in the middle of the file
		extra = big_chunk ? 1 : $urandom_range(2);
		for (int c = 0; c < extra; c++) begin
			chunk_len = big_chunk ? 32'd40 : $urandom_range(6);
			len_pos.push_back(file_q.size());
			push_word(chunk_len);
			case ($urandom_range(3))
				0: push_word(pcsp_pkg::TYPE_IEND);
				1: push_word($urandom);
				default: push_word({type_letter(), type_letter(), type_letter(), type_letter()});
			endcase
			repeat (chunk_len)
				file_q.push_back(8'($urandom));
			push_word($urandom);
		end

		// closing IEND, now and then carrying data
		chunk_len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
		len_pos.push_back(file_q.size());
		push_word(chunk_len);
		iend_type_pos = file_q.size();
		push_word(pcsp_pkg::TYPE_IEND);
		repeat (chunk_len)
			file_q.push_back(8'($urandom));
		push_word($urandom);

		if (!big_chunk) begin
			case ($urandom_range(15))
				7: file_q[24 + $urandom_range(4)] = 8'($urandom);
				8: file_q[12 + $urandom_range(3)] = 8'($urandom);
				9: file_q[8 + $urandom_range(3)] = 8'($urandom);
				10: begin
					pos = $urandom_range(1, file_q.size() - 1);
					while (file_q.size() > pos)
						file_q.delete(file_q.size() - 1);
				end
				11: file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
				12: file_q[iend_type_pos + $urandom_range(3)] = 8'($urandom);
				13: begin
					pos         = len_pos[$urandom_range(len_pos.size() - 1)];
					file_q[pos] = file_q[pos] | 8'h80;
				end
				14: begin
					pos         = $urandom_range(7);
					file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
				end
				15: begin
					file_q.delete();
					repeat ($urandom_range(1, 12))
						file_q.push_back(8'($urandom));
				end
				default: ;
			endcase
		end
	endtask

	task automatic run_random_files(input int byte_budget);
		int sent;
		sent = 0;
		while (sent < byte_budget) begin
			build_png_file(1'b0);
			sent += file_q.size();
			send_file();
		end
	endtask

	// sender goes quiet until every predicted result has been delivered
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (records_pending != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// bad first byte on the final transfer
		send_byte(8'h00, 1'b1);
		// file ends inside the signature
		send_byte(8'd137, 1'b1);
		// signature fault, then ignored bytes up to the end of the file
		send_byte(8'hFF, 1'b0);
		send_byte(8'd137, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// over-long chunk length
		for (int i = 0; i < 8; i++)
			send_byte(FILE_SIGNATURE[63 - 8 * i -: 8], 1'b0);
		repeat (4)
			send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_for_results();

		src_idle_pct = 12;
		rcv_idle_pct = 68;
		run_random_files(PHASE_BYTES);
		wait_for_results();

		src_idle_pct = 68;
		rcv_idle_pct = 12;
		run_random_files(PHASE_BYTES);
		wait_for_results();

		// no idling; a long output hold-off while a long chunk streams in
		src_idle_pct = 0;
		rcv_idle_pct = 0;
		stalls_asked++;
		build_png_file(1'b1);
		send_file();
		run_random_files(PHASE_BYTES);

		wait_for_results();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && records_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pcsp_pkg.sv
rtl/pcsp_front.sv
rtl/pcsp_queue.sv
rtl/pcsp_back.sv
rtl/png_chunk_stream_parser.sv
bench/png_parse_checker.sv
bench/tb_png_chunk_stream_parser.sv
